### rtl/lurng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurng_pkg: shared types and constants for the LFSR random source
// Holds the feedback polynomial, field widths, operation codes, sequencer
// states and the command and result bundles passed between modules.
// ----------------------------------------------------------------------------
package lurng_pkg;

    localparam int LFSR_W  = 32;
    localparam int VAL_W   = 8;
    localparam int CNT_W   = 5;
    localparam int NIB_W   = 4;
    localparam int MODE_W  = 2;
    localparam int BCNT_W  = 4;

    localparam logic [LFSR_W-1:0] LFSR_POLY   = 32'hA3AC183C;
    localparam logic [LFSR_W-1:0] LFSR_RESET  = 32'h0000_0001;
    localparam logic [VAL_W-1:0]  NORM_START  = 8'h80;

    // Remaining-step counts, stored as count minus one
    localparam logic [CNT_W-1:0]  SUM_STEPS_M1  = 5'd15;
    localparam logic [CNT_W-1:0]  NIB_STEPS_M1  = 5'd3;
    localparam logic [CNT_W-1:0]  SEED_STEPS_M1 = 5'd31;

    typedef enum logic [MODE_W-1:0] {
        MODE_UNIFORM = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_RESEED  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNIF,
        ST_NSUM,
        ST_NIB_A,
        ST_NIB_B,
        ST_SEED_INC,
        ST_SEED_FIX,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic inc;
        logic fix;
    } lfsr_cmd_t;

    typedef struct packed {
        logic [LFSR_W-1:0]       new_seed;
        logic signed [VAL_W-1:0] normal_value;
        logic [VAL_W-1:0]        uniform_value;
    } result_t;

endpackage

### rtl/lurng_lfsr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurng_lfsr: 32-bit Galois LFSR with bit-serial seed increment
// Steps once per cycle on command, loads a seed, and increments the loaded
// seed one bit per cycle as the register rotates, carrying through a flop.
// ----------------------------------------------------------------------------
module lurng_lfsr
    import lurng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lfsr_cmd_t         cmd,
    input  logic [LFSR_W-1:0] seed_in,
    output logic              new_bit,
    output logic [LFSR_W-1:0] value
);

    logic [LFSR_W-1:0] state_reg, state_next;
    logic              carry_reg, carry_next;
    logic [LFSR_W-1:0] stepped;

    // One Galois step: shift right, fold in the polynomial on a one out
    assign stepped = (state_reg >> 1) ^ ({LFSR_W{state_reg[0]}} & LFSR_POLY);
    assign new_bit = stepped[0];
    assign value   = state_reg;

    // Select the next register contents
    always_comb
    begin
        state_next = state_reg;
        carry_next = carry_reg;
        priority if (cmd.load)
        begin
            state_next = seed_in;
            carry_next = 1'b1;
        end
        else if (cmd.step)
        begin
            state_next = stepped;
        end
        else if (cmd.inc)
        begin
            // add the carry to the low bit and rotate it to the top
            state_next = {state_reg[0] ^ carry_reg, state_reg[LFSR_W-1:1]};
            carry_next = state_reg[0] & carry_reg;
        end
        else if (cmd.fix)
        begin
            // a carry out of the top means the seed wrapped to zero: skip it
            if (carry_reg)
            begin
                state_next = LFSR_RESET;
            end
        end
        else
        begin
            // hold the register when no command is active
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LFSR_RESET;
            carry_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            carry_reg <= carry_next;
        end
    end

endmodule

### rtl/lurng_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurng_seq: draw sequencer and bit-serial result assembly
// Walks one item through its LFSR steps, shifting each drawn bit into the
// uniform word, the normal sum or a 4-bit nibble (or incrementing the seed), then hands off a result.
// ----------------------------------------------------------------------------
module lurng_seq
    import lurng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mode_t             mode,
    input  logic [BCNT_W-1:0] bit_count,
    input  logic              out_free,
    input  logic              new_bit,
    input  logic [LFSR_W-1:0] lfsr_value,
    output logic              idle,
    output logic              done,
    output lfsr_cmd_t         cmd,
    output result_t           result
);

    seq_state_t        state_reg, state_next;
    mode_t             mode_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W-1:0]  draw_reg, draw_next;
    logic [NIB_W-1:0]  a_reg, a_next;
    logic [VAL_W-1:0]  sum_reg, sum_next;
    logic              last;
    logic [VAL_W-1:0]  draw_shift;
    logic [VAL_W-1:0]  norm_sum;

    assign last       = (cnt_reg == '0);
    assign draw_shift = {draw_reg[VAL_W-2:0], new_bit};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_UNIFORM:
                            state_next = (bit_count == '0) ? ST_FINISH : ST_UNIF;
                        MODE_NORMAL:  state_next = ST_NSUM;
                        MODE_RESEED:  state_next = ST_SEED_INC;
                        MODE_NONE:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_UNIF:     if (last) state_next = ST_FINISH;
            ST_NSUM:     if (last) state_next = ST_NIB_A;
            ST_NIB_A:    if (last) state_next = ST_NIB_B;
            ST_NIB_B:    if (last) state_next = ST_FINISH;
            ST_SEED_INC: if (last) state_next = ST_SEED_FIX;
            ST_SEED_FIX: state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs and LFSR commands
    always_comb
    begin
        idle     = (state_reg == ST_IDLE);
        done     = (state_reg == ST_FINISH) && out_free;
        cmd.load = (state_reg == ST_IDLE) && start && (mode == MODE_RESEED);
        cmd.step = (state_reg == ST_UNIF) || (state_reg == ST_NSUM) ||
                   (state_reg == ST_NIB_A) || (state_reg == ST_NIB_B);
        cmd.inc  = (state_reg == ST_SEED_INC);
        cmd.fix  = (state_reg == ST_SEED_FIX);
    end

    // Datapath: counter, uniform/nibble shift register, normal sum
    always_comb
    begin
        cnt_next  = cnt_reg;
        draw_next = draw_reg;
        a_next    = a_reg;
        sum_next  = sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                draw_next = '0;
                sum_next  = NORM_START;
                if (mode == MODE_NORMAL)
                    cnt_next = SUM_STEPS_M1;
                else if (mode == MODE_RESEED)
                    cnt_next = SEED_STEPS_M1;
                else
                    cnt_next = CNT_W'(bit_count - BCNT_W'(1));
            end
            ST_UNIF:
            begin
                draw_next = draw_shift;
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_NSUM:
            begin
                // add 16 per set bit: only the upper nibble moves
                sum_next = {sum_reg[VAL_W-1:NIB_W] + NIB_W'(new_bit),
                            sum_reg[NIB_W-1:0]};
                cnt_next = last ? NIB_STEPS_M1 : cnt_reg - CNT_W'(1);
            end
            ST_NIB_A:
            begin
                draw_next = last ? '0 : draw_shift;
                a_next    = last ? draw_shift[NIB_W-1:0] : a_reg;
                cnt_next  = last ? NIB_STEPS_M1 : cnt_reg - CNT_W'(1);
            end
            ST_NIB_B:
            begin
                draw_next = draw_shift;
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_SEED_INC:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_SEED_FIX,
            ST_FINISH:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Combine sum and nibbles; wraps modulo 256
    assign norm_sum = sum_reg + VAL_W'(a_reg) - VAL_W'(draw_reg[NIB_W-1:0]);

    // Result fields; unused fields read zero
    always_comb
    begin
        result.uniform_value = (mode_reg == MODE_UNIFORM) ? draw_reg : '0;
        result.normal_value  = (mode_reg == MODE_NORMAL) ? norm_sum : '0;
        result.new_seed      = (mode_reg == MODE_RESEED) ? lfsr_value : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_NONE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_IDLE) && start)
            begin
                mode_reg <= mode;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        draw_reg <= draw_next;
        a_reg    <= a_next;
        sum_reg  <= sum_next;
    end

endmodule

### rtl/lfsr_uniform_normal_rng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_uniform_normal_rng: LFSR-based uniform and approximate normal source
// Uniform and normal words are drawn from the LFSR, one step per cycle; reseed
// increments the loaded seed bit-serially, and an unused mode draws nothing.
// A new word is taken only once the sequencer is back to idle after the last
// one, while a finished result may still wait in the output register.
// Reset clears the handshake and loads the LFSR with 1.
// ----------------------------------------------------------------------------
module lfsr_uniform_normal_rng
    import lurng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] bit_count, [35:4] seed_in, [39:36] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [7:0] uniform_value, [15:8] normal_value,
                                   // [47:16] new_seed
);

    logic              idle;
    logic              start;
    logic              done;
    logic              out_free;
    logic              new_bit;
    logic [LFSR_W-1:0] lfsr_value;
    lfsr_cmd_t         cmd;
    result_t           result;
    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_valid_reg || m_tready;

    lurng_lfsr u_lfsr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .seed_in (s_tdata[35:4]),
        .new_bit (new_bit),
        .value   (lfsr_value)
    );

    lurng_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode_t'(s_tuser)),
        .bit_count  (s_tdata[3:0]),
        .out_free   (out_free),
        .new_bit    (new_bit),
        .lfsr_value (lfsr_value),
        .idle       (idle),
        .done       (done),
        .cmd        (cmd),
        .result     (result)
    );

    // Output word register: load on done, drop on handoff
    always_comb
    begin
        m_valid_next = m_valid_reg;
        priority if (done)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_data_reg <= {result.new_seed, result.normal_value, result.uniform_value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
